[sv/tba_pkg.sv]
// shared constants, types and controller codes for the temperature boxcar average
// no dependencies
package tba_pkg;

  localparam int unsigned SAMPLE_W        = 18;
  localparam int unsigned READING_W       = 17;  // positive in-range readings
  localparam int unsigned TIMES9_W        = 20;
  localparam int unsigned WINDOW_LOG2_DEF = 8;

  localparam logic signed [SAMPLE_W-1:0] LIMIT_HIGH = 18'sd85000;
  localparam logic [SAMPLE_W-1:0]        F_OFFSET   = 18'd32000;

  // divide by five as multiply by ceil(2^22/5), exact for dividends below 2^22
  localparam int unsigned              RECIP_SHIFT = 22;
  localparam int unsigned              RECIP_W     = 20;
  localparam logic [RECIP_W-1:0]       RECIP_FIVE  = 20'd838861;
  localparam int unsigned              PROD_W      = TIMES9_W + RECIP_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  typedef struct packed {
    logic load;  // capture reading
    logic mul;   // scale reading, read oldest ring entry
    logic upd;   // write ring, update sum, present result
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic out_stall;
  } status_t;

endpackage

[sv/tba_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module tba_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[sv/tba_ctrl.sv]
// controller state machine: sequences capture, scaling and ring update per request
// depends on tba_pkg
module tba_ctrl
  import tba_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        // out-of-range readings are taken and dropped
        if (in_valid_i && status_i.in_range) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        if (!status_i.out_stall) begin
          cmd_o.upd = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_mul_then_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |=> (state_q == ST_UPD))
    else $error("scaling step not followed by update");

  a_upd_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.upd |=> in_ready_o)
    else $error("controller not ready after update");

endmodule

[sv/tba_dp.sv]
// datapath: range check, celsius to fahrenheit scaling, ring, running sum, output register
// depends on tba_pkg and tba_ram
module tba_dp
  import tba_pkg::*;
#(
  parameter int unsigned WINDOW_LOG2 = WINDOW_LOG2_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [SAMPLE_W-1:0] sample_millic_i,
  input  logic                out_ready_i,
  output status_t             status_o,
  output logic                out_valid_o,
  output logic [SAMPLE_W-1:0] average_millif_o
);

  localparam int unsigned SUM_W = SAMPLE_W + WINDOW_LOG2;
  localparam int unsigned DEPTH = 2 ** WINDOW_LOG2;

  logic [READING_W-1:0]   sample_q;
  logic [PROD_W-1:0]      prod_q;
  logic [TIMES9_W-1:0]    times9;
  logic [WINDOW_LOG2-1:0] ptr_q, ptr_d;
  logic                   wrapped_q;
  logic                   first_q;
  logic [SAMPLE_W-1:0]    first_val_q;
  logic [SUM_W-1:0]       sum_q, sum_d, sum_base;
  logic [SAMPLE_W-1:0]    fahr, oldest, first_val, rd_data;
  logic                   out_valid_q;
  logic [SAMPLE_W-1:0]    out_data_q;
  logic signed [SAMPLE_W-1:0] sample_s;

  assign sample_s           = $signed(sample_millic_i);
  assign status_o.in_range  = (sample_s > 18'sd0) && (sample_s < LIMIT_HIGH);
  assign status_o.out_stall = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_millic_i[READING_W-1:0];
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(times9) * PROD_W'(RECIP_FIVE);
    end
  end

  assign times9 = {sample_q, 3'b000} + TIMES9_W'(sample_q);
  assign fahr   = prod_q[RECIP_SHIFT +: SAMPLE_W] + F_OFFSET;

  tba_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.upd),
    .wr_addr_i(ptr_q),
    .wr_data_i(fahr),
    .rd_en_i  (cmd_i.mul),
    .rd_addr_i(ptr_q),
    .rd_data_o(rd_data)
  );

  // entries not yet overwritten since the first reading still hold its value
  assign first_val = first_q ? fahr : first_val_q;
  assign oldest    = (first_q || !wrapped_q) ? first_val : rd_data;
  assign sum_base  = first_q ? {fahr, {WINDOW_LOG2{1'b0}}} : sum_q;
  assign sum_d     = sum_base - SUM_W'(oldest) + SUM_W'(fahr);
  assign ptr_d     = ptr_q + WINDOW_LOG2'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      wrapped_q   <= 1'b0;
      first_q     <= 1'b1;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        ptr_q   <= ptr_d;
        sum_q   <= sum_d;
        first_q <= 1'b0;
        if (ptr_q == {WINDOW_LOG2{1'b1}}) begin
          wrapped_q <= 1'b1;
        end
      end
      if (cmd_i.upd) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      first_val_q <= first_val;
      out_data_q  <= sum_d[WINDOW_LOG2 +: SAMPLE_W];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign average_millif_o = out_data_q;

  a_upd_never_overwrites: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |-> !(out_valid_q && !out_ready_i))
    else $error("update while previous result still pending");

  a_ptr_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd |=> (ptr_q == $past(ptr_d)) && out_valid_q && !first_q)
    else $error("pointer or result not updated after ring write");

endmodule

[sv/temperature_boxcar_average.sv]
// boxcar moving average of fahrenheit-converted temperature readings
// steps: accept in idle, scale in ST_MUL, then update ring, sum and result in ST_UPD
// ST_UPD holds while the last result is pending; readings are taken only when idle
// the ring ram read-modify-write and the reciprocal multiply set these steps
// reset: asynchronous active low; clears pointer, sum and output valid, arms preload
// depends on tba_pkg, tba_ctrl, tba_dp, tba_ram
module temperature_boxcar_average
  import tba_pkg::*;
#(
  parameter int unsigned WINDOW_LOG2 = WINDOW_LOG2_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sample_valid_i,
  output logic                sample_ready_o,
  input  logic [SAMPLE_W-1:0] sample_millic_i,
  output logic                average_valid_o,
  input  logic                average_ready_i,
  output logic [SAMPLE_W-1:0] average_millif_o
);

  cmd_t    cmd;
  status_t status;

  tba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(sample_valid_i),
    .in_ready_o(sample_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tba_dp #(
    .WINDOW_LOG2(WINDOW_LOG2)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sample_millic_i (sample_millic_i),
    .out_ready_i     (average_ready_i),
    .status_o        (status),
    .out_valid_o     (average_valid_o),
    .average_millif_o(average_millif_o)
  );

endmodule
